// ===== hw/rtl/lrud_pkg.sv =====
package lrud_pkg;

  localparam int LINES   = 64;
  localparam int IDX_W   = $clog2(LINES);
  localparam int CNT_W   = $clog2(LINES + 1);
  localparam int STAMP_W = 32;
  localparam int DEV_W   = 8;
  localparam int SEC_W   = 16;
  localparam int BLK_W   = 16;
  localparam int TAG_W   = DEV_W + SEC_W + BLK_W;
  localparam int CTR_W   = 32;

  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_INSERT = 1'b1;

  typedef struct packed {
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_tag_en;
    logic               wr_stamp_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [TAG_W-1:0]   wr_tag;
    logic [STAMP_W-1:0] wr_stamp;
  } mem_req_t;

  typedef struct packed {
    logic               valid;
    logic [TAG_W-1:0]   tag;
    logic [STAMP_W-1:0] stamp;
  } mem_rsp_t;

  typedef struct packed {
    logic             en;
    logic             lookup;
    logic             hit;
    logic [IDX_W-1:0] line;
  } fin_t;

endpackage

// ===== hw/rtl/lru_tag_directory_core.sv =====
// channel   ports                                   handshake
// --------  --------------------------------------  ----------------------------
// request   in_mode in_device in_sector             start high, busy low
//           in_block_number
// result    out_hit out_line out_hit_count          out_strobe, one cycle
//           out_miss_count
// config    cfg_data (lines_in_use)                 cfg_valid and cfg_ready
//
// a request reads the tag/stamp memory once per line for n = min(lines_in_use, 64)
// lines, then settles the last compare, then does the write-back;
// with n = 0 only the write-back cycle remains. the result strobe follows the
// write-back cycle; a new request may be accepted in the write-back cycle.
// synchronous active-low reset empties all lines and clears clock and counters.
// the receiver cannot stall; results are never held.
module lru_tag_directory_core
  import lrud_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic             in_mode,
  input  logic [DEV_W-1:0] in_device,
  input  logic [SEC_W-1:0] in_sector,
  input  logic [BLK_W-1:0] in_block_number,
  output logic             out_strobe,
  output logic             out_hit,
  output logic [5:0]       out_line,
  output logic [CTR_W-1:0] out_hit_count,
  output logic [CTR_W-1:0] out_miss_count,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [6:0]       cfg_data
);

  mem_req_t req;
  mem_rsp_t rsp;
  fin_t     fin;

  logic [6:0]       lines_r;
  logic [CNT_W-1:0] lines_n;
  logic [CTR_W-1:0] hits_r, hits_nxt;
  logic [CTR_W-1:0] misses_r, misses_nxt;
  logic             strobe_r;
  logic             hit_out_r;
  logic [5:0]       line_out_r;

  assign cfg_ready = 1'b1;

  // clip the configured count to the number of lines
  assign lines_n = (lines_r > 7'(LINES)) ? CNT_W'(LINES) : CNT_W'(lines_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lines_r <= 7'(LINES);
    end else if (cfg_valid && cfg_ready) begin
      lines_r <= cfg_data;
    end
  end

  lrud_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_mode (in_mode),
    .in_tag  ({in_device, in_sector, in_block_number}),
    .lines_n (lines_n),
    .req     (req),
    .rsp     (rsp),
    .fin     (fin)
  );

  lrud_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  always_comb begin
    hits_nxt   = hits_r;
    misses_nxt = misses_r;
    if (fin.en && fin.lookup) begin
      if (fin.hit) begin
        hits_nxt = hits_r + CTR_W'(1);
      end else begin
        misses_nxt = misses_r + CTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hits_r   <= '0;
      misses_r <= '0;
      strobe_r <= 1'b0;
    end else begin
      hits_r   <= hits_nxt;
      misses_r <= misses_nxt;
      strobe_r <= fin.en;
    end
  end

  always_ff @(posedge clk) begin
    if (fin.en) begin
      hit_out_r  <= fin.hit;
      line_out_r <= 6'(fin.line);
    end
  end

  assign out_strobe     = strobe_r;
  assign out_hit        = hit_out_r;
  assign out_line       = line_out_r;
  assign out_hit_count  = hits_r;
  assign out_miss_count = misses_r;

endmodule

// ===== hw/rtl/lrud_store.sv =====
module lrud_store
  import lrud_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  mem_req_t req,
  output mem_rsp_t rsp
);

  logic [TAG_W-1:0]   tag_mem   [LINES];
  logic [STAMP_W-1:0] stamp_mem [LINES];
  logic [LINES-1:0]   valid_r;

  logic               rd_valid_r;
  logic [TAG_W-1:0]   rd_tag_r;
  logic [STAMP_W-1:0] rd_stamp_r;

  always_ff @(posedge clk) begin
    if (req.wr_tag_en) begin
      tag_mem[req.wr_addr] <= req.wr_tag;
    end
    if (req.wr_stamp_en) begin
      stamp_mem[req.wr_addr] <= req.wr_stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_tag_r   <= tag_mem[req.rd_addr];
      rd_stamp_r <= stamp_mem[req.rd_addr];
      rd_valid_r <= valid_r[req.rd_addr];
    end
  end

  // line valid flags, all lines empty after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (req.wr_tag_en) begin
      valid_r[req.wr_addr] <= 1'b1;
    end
  end

  assign rsp.valid = rd_valid_r;
  assign rsp.tag   = rd_tag_r;
  assign rsp.stamp = rd_stamp_r;

endmodule

// ===== hw/rtl/lrud_scan.sv =====
module lrud_scan
  import lrud_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic             in_mode,
  input  logic [TAG_W-1:0] in_tag,
  input  logic [CNT_W-1:0] lines_n,
  output mem_req_t         req,
  input  mem_rsp_t         rsp,
  output fin_t             fin
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_LAST = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic               mode_r, mode_nxt;
  logic [TAG_W-1:0]   tag_r, tag_nxt;
  logic [STAMP_W-1:0] clock_r, clock_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic               pend_r, pend_nxt;
  logic [IDX_W-1:0]   pidx_r, pidx_nxt;
  logic               hit_r, hit_nxt;
  logic [IDX_W-1:0]   hline_r, hline_nxt;
  logic               empty_r, empty_nxt;
  logic               have_r, have_nxt;
  logic [STAMP_W-1:0] best_r, best_nxt;
  logic [IDX_W-1:0]   vic_r, vic_nxt;

  logic             accept;
  logic             last_issue;
  logic [IDX_W-1:0] fin_line;

  assign busy       = (state_r == ST_SCAN) || (state_r == ST_LAST);
  assign accept     = start && !busy;
  assign last_issue = ({1'b0, idx_r} == (n_r - CNT_W'(1)));

  always_comb begin
    if (hit_r) begin
      fin_line = hline_r;
    end else if (mode_r == MODE_INSERT) begin
      fin_line = vic_r;
    end else begin
      fin_line = '0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    tag_nxt   = tag_r;
    clock_nxt = clock_r;
    n_nxt     = n_r;
    idx_nxt   = idx_r;
    pend_nxt  = 1'b0;
    pidx_nxt  = pidx_r;
    hit_nxt   = hit_r;
    hline_nxt = hline_r;
    empty_nxt = empty_r;
    have_nxt  = have_r;
    best_nxt  = best_r;
    vic_nxt   = vic_r;

    unique case (state_r)
      ST_IDLE: ;
      ST_SCAN: begin
        pend_nxt = 1'b1;
        pidx_nxt = idx_r;
        idx_nxt  = idx_r + IDX_W'(1);
        if (last_issue) begin
          state_nxt = ST_LAST;
        end
      end
      ST_LAST: state_nxt = ST_FIN;
      ST_FIN:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase

    // compare the line read in the previous cycle
    if (pend_r) begin
      if (rsp.valid && (rsp.tag == tag_r) && !hit_r) begin
        hit_nxt   = 1'b1;
        hline_nxt = pidx_r;
      end
      if (!empty_r) begin
        if (!rsp.valid) begin
          empty_nxt = 1'b1;
          vic_nxt   = pidx_r;
        end else if (!have_r || (rsp.stamp < best_r)) begin
          have_nxt = 1'b1;
          best_nxt = rsp.stamp;
          vic_nxt  = pidx_r;
        end
      end
    end

    if (accept) begin
      mode_nxt  = in_mode;
      tag_nxt   = in_tag;
      clock_nxt = clock_r + STAMP_W'(1);
      n_nxt     = lines_n;
      idx_nxt   = '0;
      hit_nxt   = 1'b0;
      hline_nxt = '0;
      empty_nxt = 1'b0;
      have_nxt  = 1'b0;
      best_nxt  = '0;
      vic_nxt   = '0;
      state_nxt = (lines_n == '0) ? ST_FIN : ST_SCAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      clock_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clock_r <= clock_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r  <= mode_nxt;
    tag_r   <= tag_nxt;
    n_r     <= n_nxt;
    idx_r   <= idx_nxt;
    pidx_r  <= pidx_nxt;
    hit_r   <= hit_nxt;
    hline_r <= hline_nxt;
    empty_r <= empty_nxt;
    have_r  <= have_nxt;
    best_r  <= best_nxt;
    vic_r   <= vic_nxt;
  end

  always_comb begin
    req.rd_en       = (state_r == ST_SCAN);
    req.rd_addr     = idx_r;
    req.wr_tag_en   = (state_r == ST_FIN) && (mode_r == MODE_INSERT);
    req.wr_stamp_en = (state_r == ST_FIN) && ((mode_r == MODE_INSERT) || hit_r);
    req.wr_addr     = fin_line;
    req.wr_tag      = tag_r;
    req.wr_stamp    = clock_r;
  end

  always_comb begin
    fin.en     = (state_r == ST_FIN);
    fin.lookup = (mode_r == MODE_LOOKUP);
    fin.hit    = hit_r;
    fin.line   = fin_line;
  end

endmodule

// ===== tb/tb_lru_tag_directory_core.sv =====
module tb_lru_tag_directory_core;
  timeunit 1ns;
  timeprecision 1ps;

  import lrud_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int TAIL_CYCLES = 80;
  localparam int PHASES      = 9;
  localparam int PHASE_ITEMS = 130;

  typedef struct {
    logic             mode;
    logic [DEV_W-1:0] device;
    logic [SEC_W-1:0] sector;
    logic [BLK_W-1:0] block_number;
  } dir_req_t;

  typedef struct {
    logic             hit;
    logic [5:0]       line;
    logic [CTR_W-1:0] hit_count;
    logic [CTR_W-1:0] miss_count;
  } dir_result_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic             in_mode = MODE_LOOKUP;
  logic [DEV_W-1:0] in_device = '0;
  logic [SEC_W-1:0] in_sector = '0;
  logic [BLK_W-1:0] in_block_number = '0;
  logic             out_strobe;
  logic             out_hit;
  logic [5:0]       out_line;
  logic [CTR_W-1:0] out_hit_count;
  logic [CTR_W-1:0] out_miss_count;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [6:0]       cfg_data = '0;

  // shadow copy of the directory
  logic               line_valid [LINES];
  logic [DEV_W-1:0]   line_dev   [LINES];
  logic [SEC_W-1:0]   line_sec   [LINES];
  logic [BLK_W-1:0]   line_blk   [LINES];
  logic [STAMP_W-1:0] line_stamp [LINES];
  logic [STAMP_W-1:0] access_clk = '0;
  logic [CTR_W-1:0]   hit_total = '0;
  logic [CTR_W-1:0]   miss_total = '0;
  logic [6:0]         lines_cfg = 7'd64;

  dir_req_t    pending_reqs [$];
  dir_req_t    tag_pool [$];
  dir_result_t expected_results [$];
  dir_req_t    cur_req;

  int sender_idle_pct = 0;
  int gap_left = 0;
  int items_open = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  lru_tag_directory_core u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_device       (in_device),
    .in_sector       (in_sector),
    .in_block_number (in_block_number),
    .out_strobe      (out_strobe),
    .out_hit         (out_hit),
    .out_line        (out_line),
    .out_hit_count   (out_hit_count),
    .out_miss_count  (out_miss_count),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  always #2 clk = ~clk;

  initial begin
    for (int i = 0; i < LINES; i++) begin
      line_valid[i] = 1'b0;
      line_dev[i]   = '0;
      line_sec[i]   = '0;
      line_blk[i]   = '0;
      line_stamp[i] = '0;
    end
  end

  function automatic dir_result_t predict_access(dir_req_t r);
    int          n;
    int          idx;
    bit          found;
    bit          empty_seen;
    bit          have_valid;
    logic [STAMP_W-1:0] oldest;
    dir_result_t res;
    n = (int'(lines_cfg) > LINES) ? LINES : int'(lines_cfg);
    access_clk = access_clk + STAMP_W'(1);
    found = 1'b0;
    idx = 0;
    for (int i = 0; i < n; i++) begin
      if (!found && line_valid[i] && line_dev[i] == r.device &&
          line_sec[i] == r.sector && line_blk[i] == r.block_number) begin
        found = 1'b1;
        idx = i;
      end
    end
    if (r.mode == MODE_LOOKUP) begin
      if (found) begin
        hit_total = hit_total + CTR_W'(1);
        line_stamp[idx] = access_clk;
      end else begin
        miss_total = miss_total + CTR_W'(1);
        idx = 0;
      end
    end else begin
      if (!found) begin
        // lowest empty line first, else oldest stamp, lowest index on ties
        idx = 0;
        empty_seen = 1'b0;
        have_valid = 1'b0;
        oldest = '0;
        for (int i = 0; i < n; i++) begin
          if (!empty_seen) begin
            if (!line_valid[i]) begin
              idx = i;
              empty_seen = 1'b1;
            end else if (!have_valid || line_stamp[i] < oldest) begin
              have_valid = 1'b1;
              oldest = line_stamp[i];
              idx = i;
            end
          end
        end
      end
      line_valid[idx] = 1'b1;
      line_dev[idx]   = r.device;
      line_sec[idx]   = r.sector;
      line_blk[idx]   = r.block_number;
      line_stamp[idx] = access_clk;
    end
    res.hit        = found;
    res.line       = idx[5:0];
    res.hit_count  = hit_total;
    res.miss_count = miss_total;
    return res;
  endfunction

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
      mismatches++;
    end
  endfunction

  task automatic add_req(logic mode, logic [DEV_W-1:0] dev, logic [SEC_W-1:0] sec,
                         logic [BLK_W-1:0] blk);
    dir_req_t r;
    r.mode = mode;
    r.device = dev;
    r.sector = sec;
    r.block_number = blk;
    pending_reqs.push_back(r);
    items_open++;
  endtask

  // a pool of tags, some differing from a neighbor in a single bit
  task automatic build_pool(int count);
    dir_req_t t;
    int       which;
    tag_pool.delete();
    for (int i = 0; i < count; i++) begin
      t.mode = MODE_LOOKUP;
      if (i > 0 && $urandom_range(3) == 0) begin
        t = tag_pool[$urandom_range(i - 1)];
        which = $urandom_range(2);
        if (which == 0) t.device[$urandom_range(DEV_W - 1)] ^= 1'b1;
        else if (which == 1) t.sector[$urandom_range(SEC_W - 1)] ^= 1'b1;
        else t.block_number[$urandom_range(BLK_W - 1)] ^= 1'b1;
      end else begin
        t.device = DEV_W'($urandom);
        t.sector = SEC_W'($urandom);
        t.block_number = BLK_W'($urandom);
      end
      tag_pool.push_back(t);
    end
  endtask

  task automatic add_random_reqs(int count);
    dir_req_t t;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 12) begin
        t.device = DEV_W'($urandom);
        t.sector = SEC_W'($urandom);
        t.block_number = BLK_W'($urandom);
      end else begin
        t = tag_pool[$urandom_range(tag_pool.size() - 1)];
      end
      add_req($urandom_range(1) ? MODE_INSERT : MODE_LOOKUP, t.device, t.sector,
              t.block_number);
    end
  endtask

  task automatic write_lines_cfg(logic [6:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    lines_cfg = value;
    cfg_valid <= 1'b0;
    cfg_data  <= 7'($urandom);
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (items_open != 0);
    repeat (2) @(posedge clk);
  endtask

  // request driver
  always @(posedge clk) begin : drive_requests
    logic taken;
    taken = start && !busy;
    if (rst_n) begin
      if (taken) expected_results.push_back(predict_access(cur_req));
      if (!start || taken) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start <= 1'b0;
        end else if (pending_reqs.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          cur_req = pending_reqs.pop_front();
          start           <= 1'b1;
          in_mode         <= cur_req.mode;
          in_device       <= cur_req.device;
          in_sector       <= cur_req.sector;
          in_block_number <= cur_req.block_number;
        end else begin
          start           <= 1'b0;
          // junk on the fields while start is low
          in_mode         <= 1'($urandom_range(1));
          in_device       <= DEV_W'($urandom);
          in_sector       <= SEC_W'($urandom);
          in_block_number <= BLK_W'($urandom);
          if (pending_reqs.size() > 0 && sender_idle_pct > 0 && $urandom_range(3) == 0)
            gap_left <= $urandom_range(1, 80);
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : check_results
    dir_result_t want;
    if (rst_n && out_strobe) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with no request outstanding, hit %0d line %0d", $time,
                 out_hit, out_line);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        items_open--;
        check_field("hit", 32'(want.hit), 32'(out_hit));
        check_field("line", 32'(want.line), 32'(out_line));
        check_field("hit_count", want.hit_count, out_hit_count);
        check_field("miss_count", want.miss_count, out_miss_count);
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_lru_tag_directory_core NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [6:0] phase_cfg [PHASES];
    int         phase_idle [PHASES];
    int         n_active;
    phase_cfg  = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd2, 7'($urandom_range(3, 63)), 7'd16,
                   7'($urandom_range(0, 127)), 7'd64};
    phase_idle = '{6, 6, 6, 51, 51, 51, 0, 0, 0};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: three lines, fill, restamp, evict the oldest, update in place
    sender_idle_pct = 6;
    write_lines_cfg(7'd3);
    add_req(MODE_LOOKUP, 8'h00, 16'h0000, 16'h0000);
    add_req(MODE_INSERT, 8'h00, 16'h0000, 16'h0000);
    add_req(MODE_INSERT, 8'hff, 16'hffff, 16'hffff);
    add_req(MODE_INSERT, 8'h5a, 16'h1234, 16'habcd);
    add_req(MODE_LOOKUP, 8'h00, 16'h0000, 16'h0000);
    add_req(MODE_INSERT, 8'ha5, 16'hedcb, 16'h5432);
    add_req(MODE_LOOKUP, 8'hff, 16'hffff, 16'hffff);
    add_req(MODE_INSERT, 8'h5a, 16'h1234, 16'habcd);
    add_req(MODE_LOOKUP, 8'ha5, 16'hedcb, 16'h5432);
    add_req(MODE_INSERT, 8'hff, 16'hffff, 16'hffff);
    add_req(MODE_LOOKUP, 8'hff, 16'hfffe, 16'hffff);
    add_req(MODE_LOOKUP, 8'hfe, 16'hffff, 16'hffff);
    add_req(MODE_LOOKUP, 8'hff, 16'hffff, 16'h7fff);
    add_req(MODE_INSERT, 8'hff, 16'hffff, 16'h7fff);
    add_req(MODE_LOOKUP, 8'hff, 16'hffff, 16'hffff);
    add_req(MODE_LOOKUP, 8'h5a, 16'h1234, 16'habcd);
    add_req(MODE_INSERT, 8'h01, 16'h8000, 16'h0001);
    add_req(MODE_LOOKUP, 8'h01, 16'h8000, 16'h0001);
    wait_drained();

    // lines beyond the active count are not searched
    write_lines_cfg(7'd1);
    add_req(MODE_LOOKUP, 8'h5a, 16'h1234, 16'habcd);
    add_req(MODE_INSERT, 8'h80, 16'h00ff, 16'hff00);
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      sender_idle_pct = phase_idle[p];
      write_lines_cfg(phase_cfg[p]);
      n_active = (int'(phase_cfg[p]) > LINES) ? LINES : int'(phase_cfg[p]);
      build_pool($urandom_range(1, 2 * n_active + 4));
      add_random_reqs(PHASE_ITEMS);
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      $display("%0t: %0d results never arrived", $time, expected_results.size());
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("tb_lru_tag_directory_core OK");
    end else begin
      $display("tb_lru_tag_directory_core NOT OK");
    end
    $finish;
  end

endmodule
